>>> rtl/sfc_pkg.sv
// Package: shared types and constants for the servo frame codec.
package sfc_pkg;

    localparam int SFC_QDEPTH = 4;
    localparam int SFC_QPTR_W = $clog2(SFC_QDEPTH);
    localparam int SFC_WIN_DEPTH = 7;
    localparam int SFC_IDX_W = 4;

    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] REG_GOAL_POS  = 8'h1E;
    localparam logic [7:0] REG_SPEED     = 8'h20;
    localparam logic [7:0] REG_PRES_POS  = 8'h24;
    localparam logic [7:0] LEN_WRITE     = 8'h05;
    localparam logic [7:0] LEN_READ      = 8'h04;
    localparam logic [7:0] INST_WRITE    = 8'h03;
    localparam logic [7:0] INST_READ     = 8'h02;
    localparam logic [7:0] READ_COUNT    = 8'h02;
    localparam logic [15:0] VALUE_MAX    = 16'd1023;

    localparam logic [SFC_IDX_W-1:0] WRITE_LAST_IDX = 4'd8;
    localparam logic [SFC_IDX_W-1:0] READ_LAST_IDX  = 4'd7;

    typedef enum logic [1:0] {
        ACT_GOAL  = 2'd0,
        ACT_SPEED = 2'd1,
        ACT_READ  = 2'd2,
        ACT_RX    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_POS    = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_REJECT = 2'd2,
        OP_POS    = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] id;
        logic [7:0] regaddr;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] chk;
    } t_desc;

endpackage

>>> rtl/sfc_front.sv
// Front end: accepts items, builds frame descriptors, runs the receive window.
module sfc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_action,
    input  logic [7:0]    i_servo_id,
    input  logic [15:0]   i_value,
    input  logic [7:0]    i_rx_byte,
    output logic          o_push,
    output sfc_pkg::t_desc o_desc
);
    import sfc_pkg::*;

    logic [7:0] r_win [SFC_WIN_DEPTH];
    logic [7:0] n_win [SFC_WIN_DEPTH];
    logic [7:0] reg_sel;
    logic [7:0] wr_sum;
    logic [7:0] win_sum;
    logic       win_hit;
    t_action    act;

    assign act     = t_action'(i_action);
    assign reg_sel = (act == ACT_GOAL) ? REG_GOAL_POS : REG_SPEED;
    assign wr_sum  = i_servo_id + LEN_WRITE + INST_WRITE + reg_sel
                   + i_value[7:0] + i_value[15:8];
    assign win_sum = r_win[2] + r_win[3] + r_win[4] + r_win[5] + r_win[6] + i_rx_byte;
    assign win_hit = (r_win[0] == SYNC_BYTE) && (r_win[1] == SYNC_BYTE)
                   && (win_sum == SYNC_BYTE);

    always_comb begin
        o_push         = 1'b0;
        o_desc.op      = OP_WRITE;
        o_desc.id      = i_servo_id;
        o_desc.regaddr = reg_sel;
        o_desc.lo      = i_value[7:0];
        o_desc.hi      = i_value[15:8];
        o_desc.chk     = ~wr_sum;
        n_win          = r_win;
        unique case (act) inside
            ACT_GOAL, ACT_SPEED: begin
                o_push = i_valid;
                if (i_value > VALUE_MAX) begin
                    o_desc.op = OP_REJECT;
                end
            end
            ACT_READ: begin
                o_push         = i_valid;
                o_desc.op      = OP_READ;
                o_desc.regaddr = REG_PRES_POS;
                o_desc.chk     = ~(i_servo_id + LEN_READ + INST_READ + REG_PRES_POS
                                   + READ_COUNT);
                if (i_valid) begin
                    for (int i = 0; i < SFC_WIN_DEPTH; i++) n_win[i] = '0;
                end
            end
            ACT_RX: begin
                o_desc.op = OP_POS;
                o_desc.lo = r_win[5];
                o_desc.hi = r_win[6];
                if (i_valid) begin
                    if (win_hit) begin
                        o_push = 1'b1;
                        for (int i = 0; i < SFC_WIN_DEPTH; i++) n_win[i] = '0;
                    end else begin
                        for (int i = 0; i < SFC_WIN_DEPTH - 1; i++) n_win[i] = r_win[i+1];
                        n_win[SFC_WIN_DEPTH-1] = i_rx_byte;
                    end
                end
            end
            default: o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SFC_WIN_DEPTH; i++) r_win[i] <= '0;
        end else begin
            r_win <= n_win;
        end
    end

endmodule

>>> rtl/sfc_fifo.sv
// Descriptor queue between front end and frame sender.
module sfc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfc_pkg::t_desc i_desc,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_avail,
    output sfc_pkg::t_desc o_desc
);
    import sfc_pkg::*;

    t_desc                r_mem [SFC_QDEPTH];
    logic [SFC_QPTR_W-1:0] r_wr;
    logic [SFC_QPTR_W-1:0] r_rd;
    logic [SFC_QPTR_W:0]   r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_cnt == (SFC_QPTR_W+1)'(SFC_QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_desc  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/sfc_back.sv
// Frame sender: expands descriptors into result items through an output register.
module sfc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  sfc_pkg::t_desc i_desc,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_tx_byte,
    output logic [15:0]    o_position,
    output logic           o_last
);
    import sfc_pkg::*;

    logic [SFC_IDX_W-1:0] r_idx;
    logic                 r_valid;
    t_kind                r_kind;
    logic [7:0]           r_tx;
    logic [15:0]          r_pos;
    logic                 r_last;

    t_kind       n_kind;
    logic [7:0]  n_tx;
    logic [15:0] n_pos;
    logic        n_last;
    logic        advance;
    logic        emit;

    assign advance = !r_valid || i_ready;
    assign emit    = advance && i_avail;
    assign o_pop   = emit && n_last;

    always_comb begin
        n_kind = KIND_TX;
        n_tx   = '0;
        n_pos  = '0;
        n_last = 1'b1;
        unique case (i_desc.op)
            OP_WRITE: begin
                n_last = (r_idx == WRITE_LAST_IDX);
                case (r_idx) inside
                    4'd0, 4'd1: n_tx = SYNC_BYTE;
                    4'd2:       n_tx = i_desc.id;
                    4'd3:       n_tx = LEN_WRITE;
                    4'd4:       n_tx = INST_WRITE;
                    4'd5:       n_tx = i_desc.regaddr;
                    4'd6:       n_tx = i_desc.lo;
                    4'd7:       n_tx = i_desc.hi;
                    default:    n_tx = i_desc.chk;
                endcase
            end
            OP_READ: begin
                n_last = (r_idx == READ_LAST_IDX);
                case (r_idx) inside
                    4'd0, 4'd1: n_tx = SYNC_BYTE;
                    4'd2:       n_tx = i_desc.id;
                    4'd3:       n_tx = LEN_READ;
                    4'd4:       n_tx = INST_READ;
                    4'd5:       n_tx = i_desc.regaddr;
                    4'd6:       n_tx = READ_COUNT;
                    default:    n_tx = i_desc.chk;
                endcase
            end
            OP_REJECT: n_kind = KIND_REJECT;
            OP_POS: begin
                n_kind = KIND_POS;
                n_pos  = {i_desc.hi, i_desc.lo};
            end
            default: n_kind = KIND_TX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (advance) begin
            r_valid <= i_avail;
            if (emit) begin
                r_idx <= n_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= n_kind;
            r_tx   <= n_tx;
            r_pos  <= n_pos;
            r_last <= n_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_tx_byte  = r_tx;
    assign o_position = r_pos;
    assign o_last     = r_last;

endmodule

>>> rtl/servo_frame_codec_top.sv
// Top level: servo bus frame encoder and position reply decoder.
//
// Channel  Dir  Width         Contents
// s_*      in   tdata 32/u 2  item: servo_id, value, rx_byte; tuser action
// m_*      out  tdata 24/u 2  item: tx_byte, position; tuser kind; tlast last
//
// Write command: 9 items, one per cycle while m_tready is high; read request:
// 8 items; reject or decoded position: 1 item. Received bytes are taken one
// per cycle. Input side is throttled only by the 4-entry descriptor queue, so
// items keep coming in while the sender is busy on a frame or stalled by m_tready.
// Synchronous active-low reset clears the receive window, queue and output.
module servo_frame_codec_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] servo_id, [23:8] value, [31:24] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] tx_byte, [23:8] position
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import sfc_pkg::*;

    logic  q_full;
    logic  q_avail;
    logic  q_pop;
    logic  f_push;
    t_desc f_desc;
    t_desc q_desc;
    logic  acc;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;

    sfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (acc),
        .i_action   (s_tuser),
        .i_servo_id (s_tdata[7:0]),
        .i_value    (s_tdata[23:8]),
        .i_rx_byte  (s_tdata[31:24]),
        .o_push     (f_push),
        .o_desc     (f_desc)
    );

    sfc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_desc  (f_desc),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_avail (q_avail),
        .o_desc  (q_desc)
    );

    sfc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (q_avail),
        .i_desc     (q_desc),
        .o_pop      (q_pop),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_kind     (m_tuser),
        .o_tx_byte  (m_tdata[7:0]),
        .o_position (m_tdata[23:8]),
        .o_last     (m_tlast)
    );

endmodule

>>> rtl/sfc_checker.sv
// Checker: port-level assertions for the servo frame codec, bound to the top.
module sfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import sfc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == KIND_REJECT |-> m_tlast && m_tdata == '0)
        else $error("reject item malformed");

    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == KIND_POS |-> m_tlast && m_tdata[7:0] == '0)
        else $error("position item malformed");

    a_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == KIND_TX |-> m_tdata[23:8] == '0)
        else $error("transmit item carries a position");

endmodule

bind servo_frame_codec_top sfc_checker u_sfc_checker (.*);
